// ===== rtl/sadm_pkg.sv =====
`timescale 1ns / 1ps

package sadm_pkg;

	// Memory geometry: words are split over an even and an odd bank
	localparam int unsigned MEM_WORDS  = 65536;
	localparam int unsigned BANK_DEPTH = (MEM_WORDS + 1) / 2;
	localparam int unsigned ROW_W      = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
	localparam int unsigned IDX_W      = 30;

	localparam logic       CMD_READ  = 1'b0;
	localparam logic       CMD_WRITE = 1'b1;

	localparam logic [3:0] SIZE_BYTE  = 4'd1;
	localparam logic [3:0] SIZE_HALF  = 4'd2;
	localparam logic [3:0] SIZE_WORD  = 4'd4;
	localparam logic [3:0] SIZE_DWORD = 4'd8;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_SIZE = 2'd1,
		ST_RANGE    = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		SK_BYTE,
		SK_HALF,
		SK_WORD,
		SK_DWORD
	} size_kind_t;

	// Per-request controls from the decoder to the banks and the result stage
	typedef struct packed {
		status_t             status;
		logic                is_read;
		size_kind_t          kind;
		logic                bank_sel;
		logic [1:0]          lane;
		logic [ROW_W-1:0]    row;
		logic [3:0]          be_even;
		logic [3:0]          be_odd;
		logic [31:0]         wdata_even;
		logic [31:0]         wdata_odd;
	} req_dec_t;

	// What the result stage needs to know about a request in flight
	typedef struct packed {
		status_t     status;
		logic        is_read;
		size_kind_t  kind;
		logic        bank_sel;
		logic [1:0]  lane;
	} resp_meta_t;

endpackage

// ===== rtl/sadm_bank.sv =====
`timescale 1ns / 1ps

module sadm_bank (
	input  logic                       clk,
	input  logic                       rd_en,
	input  logic [sadm_pkg::ROW_W-1:0] row,
	input  logic [3:0]                 be,
	input  logic [31:0]                wdata,
	output logic [31:0]                rdata
);
	import sadm_pkg::*;

	logic [31:0] mem [BANK_DEPTH];
	logic [31:0] rdata_q;

	// Byte-lane writes merge into the stored word without a read
	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			if (be[i]) begin
				mem[row][8*i +: 8] <= wdata[8*i +: 8];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem[row];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/sadm_decode.sv =====
`timescale 1ns / 1ps

module sadm_decode (
	input  logic               cmd,
	input  logic [31:0]        byte_address,
	input  logic [3:0]         access_size,
	input  logic [63:0]        write_data,
	output sadm_pkg::req_dec_t dec
);
	import sadm_pkg::*;

	logic [IDX_W-1:0] idx;
	logic [IDX_W:0]   last_word;
	logic             size_ok;
	size_kind_t       kind;
	status_t          status;
	logic             do_write;
	logic [3:0]       be_word;
	logic [31:0]      wdata_word;

	assign idx = byte_address[31:2];

	always_comb begin
		size_ok = 1'b1;
		kind    = SK_BYTE;
		unique case (access_size)
			SIZE_BYTE:  kind = SK_BYTE;
			SIZE_HALF:  kind = SK_HALF;
			SIZE_WORD:  kind = SK_WORD;
			SIZE_DWORD: kind = SK_DWORD;
			default:    size_ok = 1'b0;
		endcase
	end

	// A doubleword touches the odd word of its pair last
	assign last_word = (kind == SK_DWORD) ? {1'b0, idx[IDX_W-1:1], 1'b1} : {1'b0, idx};

	always_comb begin
		priority if (!size_ok) begin
			status = ST_BAD_SIZE;
		end else if (last_word >= (IDX_W+1)'(MEM_WORDS)) begin
			status = ST_RANGE;
		end else begin
			status = ST_OK;
		end
	end

	assign do_write = (cmd == CMD_WRITE) && (status == ST_OK);

	// Place narrow store data on its lanes
	always_comb begin
		unique case (kind)
			SK_BYTE: begin
				be_word    = 4'b0001 << byte_address[1:0];
				wdata_word = {4{write_data[7:0]}};
			end
			SK_HALF: begin
				be_word    = byte_address[1] ? 4'b1100 : 4'b0011;
				wdata_word = {2{write_data[15:0]}};
			end
			default: begin
				be_word    = 4'b1111;
				wdata_word = write_data[31:0];
			end
		endcase
	end

	always_comb begin
		dec.status     = status;
		dec.is_read    = (cmd == CMD_READ);
		dec.kind       = kind;
		dec.bank_sel   = idx[0];
		dec.lane       = byte_address[1:0];
		dec.row        = idx[ROW_W:1];
		dec.be_even    = 4'b0000;
		dec.be_odd     = 4'b0000;
		dec.wdata_even = wdata_word;
		dec.wdata_odd  = wdata_word;
		if (do_write) begin
			if (kind == SK_DWORD) begin
				dec.be_even   = 4'b1111;
				dec.be_odd    = 4'b1111;
				dec.wdata_odd = write_data[63:32];
			end else if (idx[0]) begin
				dec.be_odd  = be_word;
			end else begin
				dec.be_even = be_word;
			end
		end
	end

endmodule

// ===== rtl/sadm_format.sv =====
`timescale 1ns / 1ps

module sadm_format (
	input  sadm_pkg::resp_meta_t meta,
	input  logic [31:0]          even_word,
	input  logic [31:0]          odd_word,
	output logic [63:0]          read_data,
	output logic [1:0]           status
);
	import sadm_pkg::*;

	logic [31:0] word;
	logic [31:0] shifted;

	assign word    = meta.bank_sel ? odd_word : even_word;
	assign shifted = word >> {meta.lane, 3'b000};

	always_comb begin
		read_data = 64'd0;
		if (meta.is_read && (meta.status == ST_OK)) begin
			unique case (meta.kind)
				SK_BYTE:  read_data = {56'd0, shifted[7:0]};
				// halfwords ignore address bit 0
				SK_HALF:  read_data = meta.lane[1] ? {48'd0, word[31:16]} : {48'd0, word[15:0]};
				SK_WORD:  read_data = {32'd0, word};
				SK_DWORD: read_data = {odd_word, even_word};
				default:  read_data = 64'd0;
			endcase
		end
	end

	assign status = meta.status;

endmodule

// ===== rtl/sized_access_data_memory_top.sv =====
`timescale 1ns / 1ps
// Channel  | Handshake           | Payload
// request  | in_valid, in_stall  | cmd, byte_address, access_size, write_data
// response | out_valid, out_stall| read_data, status
//
// One request per cycle unless in_stall is raised; its response appears in the cycle after acceptance.
// Stores write the even/odd word banks with byte enables at acceptance; loads
// read both banks at acceptance and are formatted from the registered read data.
// Reset clears only the response valid; memory contents are undefined until written.
// A stalled response holds the request channel off; a draining response does not.

module sized_access_data_memory_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cmd,
	input  logic [31:0] byte_address,
	input  logic [3:0]  access_size,
	input  logic [63:0] write_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] read_data,
	output logic [1:0]  status
);
	import sadm_pkg::*;

	req_dec_t    dec;
	resp_meta_t  meta_s1;
	logic        valid_s1;
	logic        accept;
	logic [31:0] even_word;
	logic [31:0] odd_word;

	assign in_stall = valid_s1 && out_stall;
	assign accept   = in_valid && !in_stall;

	sadm_decode u_decode (
		.cmd          (cmd),
		.byte_address (byte_address),
		.access_size  (access_size),
		.write_data   (write_data),
		.dec          (dec)
	);

	sadm_bank u_bank_even (
		.clk   (clk),
		.rd_en (accept && dec.is_read),
		.row   (dec.row),
		.be    (accept ? dec.be_even : 4'b0000),
		.wdata (dec.wdata_even),
		.rdata (even_word)
	);

	sadm_bank u_bank_odd (
		.clk   (clk),
		.rd_en (accept && dec.is_read),
		.row   (dec.row),
		.be    (accept ? dec.be_odd : 4'b0000),
		.wdata (dec.wdata_odd),
		.rdata (odd_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (!out_stall) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			meta_s1.status   <= dec.status;
			meta_s1.is_read  <= dec.is_read;
			meta_s1.kind     <= dec.kind;
			meta_s1.bank_sel <= dec.bank_sel;
			meta_s1.lane     <= dec.lane;
		end
	end

	sadm_format u_format (
		.meta      (meta_s1),
		.even_word (even_word),
		.odd_word  (odd_word),
		.read_data (read_data),
		.status    (status)
	);

	assign out_valid = valid_s1;

	a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("request stalled without a blocked response");

	a_accept_gives_response: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> out_valid)
		else $error("accepted request gave no response");

	a_drain_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !in_valid) |=> !out_valid)
		else $error("response repeated after being taken");

	a_error_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status != ST_OK)) |-> (read_data == 64'd0))
		else $error("error response carries data");

	a_no_write_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && (dec.status != ST_OK)) |-> ((dec.be_even == 4'b0000) && (dec.be_odd == 4'b0000)))
		else $error("rejected request enables a write");

endmodule
